// ===== hdl/rpq_pkg.sv =====
// ----------------------------------------------------------------------------
// rpq_pkg
// Shared types, codes and constants of the retransmit priority queue.
// ----------------------------------------------------------------------------
package rpq_pkg;

  localparam int DEFAULT_CAPACITY = 16;

  localparam int NODE_W   = 16;
  localparam int SENDS_W  = 8;
  localparam int STAMP_W  = 32;
  localparam int OCC_OUT_W = 5;
  localparam int STATUS_W = 2;

  // APB register map
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam logic REG_TRANSMIT_LIMIT = 1'b0;   // word index, paddr[2]
  localparam logic [SENDS_W-1:0] LIMIT_RESET = 8'd3;

  // Operation codes
  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_POP  = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

  typedef struct packed {
    logic [NODE_W-1:0]  node;
    logic [SENDS_W-1:0] sends;
    logic [STAMP_W-1:0] stamp;
  } entry_t;

  // Controller to datapath
  typedef struct packed {
    logic start;    // latch the input transaction, clear the scan
    logic issue;    // read the slot at the scan pointer, advance it
    logic finish;   // write back and load the result register
  } rpq_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic scan_last;  // scan pointer is at the last slot
    logic out_space;  // result register can take a new result
  } rpq_stat_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_LAST,
    ST_WRITE
  } rpq_state_t;

endpackage

// ===== hdl/rpq_if.sv =====
// ----------------------------------------------------------------------------
// rpq_if
// Valid/ready channels of the retransmit priority queue.
// ----------------------------------------------------------------------------
interface rpq_in_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [15:0] node_id;

  modport source (output valid, output cmd, output node_id, input ready);
  modport sink (input valid, input cmd, input node_id, output ready);
endinterface

interface rpq_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] sent_node;
  logic [1:0]  status;
  logic        retired;
  logic [4:0]  occupancy;

  modport source (output valid, output sent_node, output status, output retired,
                  output occupancy, input ready);
  modport sink (input valid, input sent_node, input status, input retired,
                input occupancy, output ready);
endinterface

// ===== hdl/rpq_ctrl.sv =====
// ----------------------------------------------------------------------------
// rpq_ctrl
// Sequencer: accept, scan every slot, compare the last, write back.
// ----------------------------------------------------------------------------
module rpq_ctrl
  import rpq_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  rpq_stat_t stat,
  output rpq_cmd_t  cmd
);

  rpq_state_t state;
  rpq_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.start  = 1'b1;
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.issue = 1'b1;
        if (stat.scan_last) begin
          state_next = ST_LAST;
        end
      end
      ST_LAST: begin
        state_next = ST_WRITE;
      end
      ST_WRITE: begin
        if (stat.out_space) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== hdl/rpq_dp.sv =====
// ----------------------------------------------------------------------------
// rpq_dp
// Slot table, scan compare, write-back and result register.
// ----------------------------------------------------------------------------
module rpq_dp
  import rpq_pkg::*;
#(
  parameter int CAPACITY = DEFAULT_CAPACITY
) (
  input  logic                clk,
  input  logic                rst,
  input  rpq_cmd_t            cmd,
  output rpq_stat_t           stat,
  input  logic                in_cmd,
  input  logic [NODE_W-1:0]   in_node_id,
  input  logic [SENDS_W-1:0]  transmit_limit,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [NODE_W-1:0]   out_sent_node,
  output logic [STATUS_W-1:0] out_status,
  output logic                out_retired,
  output logic [OCC_OUT_W-1:0] out_occupancy
);

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int OCC_W = $clog2(CAPACITY + 1);

  // Entry memory, one read and one write port
  entry_t mem [CAPACITY];
  logic [CAPACITY-1:0] slot_valid;

  logic               op;
  logic [NODE_W-1:0]  node_q;
  logic [IDX_W-1:0]   ptr;
  logic [IDX_W-1:0]   rd_idx;
  entry_t             rd_data;
  logic               rd_vld_slot;
  logic               cmp_en;

  logic               hit_found;
  logic [IDX_W-1:0]   hit_idx;
  logic               free_found;
  logic [IDX_W-1:0]   free_idx;
  logic               best_found;
  logic [IDX_W-1:0]   best_idx;
  entry_t             best;

  logic [STAMP_W-1:0] stamp_counter;
  logic [OCC_W-1:0]   occ;

  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;
  entry_t             wr_data;
  logic               set_valid;
  logic               clr_valid;
  logic [OCC_W-1:0]   occ_next;
  logic [OCC_W+OCC_OUT_W-1:0] occ_ext;
  logic [NODE_W-1:0]  res_node;
  logic [STATUS_W-1:0] res_status;
  logic               res_retired;
  logic [SENDS_W:0]   sends_inc;
  logic               take_best;

  assign stat.scan_last = (ptr == IDX_W'(CAPACITY - 1));
  assign stat.out_space = !out_valid || out_ready;

  // Latch the transaction and walk the scan pointer
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      op     <= in_cmd;
      node_q <= in_node_id;
    end
    if (cmd.start) begin
      ptr <= '0;
    end else if (cmd.issue) begin
      ptr <= ptr + 1'b1;
    end
  end

  // Registered read of one slot per cycle
  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      rd_data     <= mem[ptr];
      rd_vld_slot <= slot_valid[ptr];
      rd_idx      <= ptr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cmp_en <= 1'b0;
    end else begin
      cmp_en <= cmd.issue;
    end
  end

  // Fewest sends first; on equal sends the larger stamp; lowest slot keeps ties
  assign take_best = rd_vld_slot &&
                     (!best_found || (rd_data.sends < best.sends) ||
                      ((rd_data.sends == best.sends) && (rd_data.stamp > best.stamp)));

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      hit_found  <= 1'b0;
      free_found <= 1'b0;
      best_found <= 1'b0;
    end else if (cmp_en) begin
      if (!hit_found && rd_vld_slot && (rd_data.node == node_q)) begin
        hit_found <= 1'b1;
        hit_idx   <= rd_idx;
      end
      if (!free_found && !rd_vld_slot) begin
        free_found <= 1'b1;
        free_idx   <= rd_idx;
      end
      if (take_best) begin
        best_found <= 1'b1;
        best_idx   <= rd_idx;
        best       <= rd_data;
      end
    end
  end

  // Write-back decision
  always_comb begin
    wr_en       = 1'b0;
    wr_addr     = best_idx;
    wr_data     = best;
    set_valid   = 1'b0;
    clr_valid   = 1'b0;
    occ_next    = occ;
    res_node    = '0;
    res_status  = STATUS_DONE;
    res_retired = 1'b0;
    sends_inc   = {1'b0, best.sends} + 1'b1;
    if (op == CMD_PUSH) begin
      wr_addr       = hit_found ? hit_idx : free_idx;
      wr_data.node  = node_q;
      wr_data.sends = '0;
      wr_data.stamp = stamp_counter + 1'b1;
      if (hit_found || free_found) begin
        wr_en     = 1'b1;
        set_valid = 1'b1;
        if (!hit_found) begin
          occ_next = occ + 1'b1;
        end
      end else begin
        res_status = STATUS_FULL;
      end
    end else begin
      if (best_found) begin
        res_node = best.node;
        if (sends_inc >= {1'b0, transmit_limit}) begin
          clr_valid   = 1'b1;
          res_retired = 1'b1;
          occ_next    = occ - 1'b1;
        end else begin
          wr_en         = 1'b1;
          wr_data.sends = sends_inc[SENDS_W-1:0];
        end
      end else begin
        res_status = STATUS_EMPTY;
      end
    end
  end

  assign occ_ext = {{OCC_OUT_W{1'b0}}, occ_next};

  always_ff @(posedge clk) begin
    if (cmd.finish && wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid    <= '0;
      occ           <= '0;
      stamp_counter <= '0;
    end else if (cmd.finish) begin
      occ <= occ_next;
      if (set_valid) begin
        slot_valid[wr_addr] <= 1'b1;
        stamp_counter       <= wr_data.stamp;
      end
      if (clr_valid) begin
        slot_valid[best_idx] <= 1'b0;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_sent_node <= res_node;
      out_status    <= res_status;
      out_retired   <= res_retired;
      out_occupancy <= occ_ext[OCC_OUT_W-1:0];
    end
  end

endmodule

// ===== hdl/retransmit_priority_queue.sv =====
// ----------------------------------------------------------------------------
// retransmit_priority_queue
// Broadcast retransmit table with fewest-sends, newest-first service.
// ----------------------------------------------------------------------------
// Each transaction on the input channel pushes a node handle (cmd 0) or pops
// the next node to broadcast (cmd 1), and yields exactly one result on the
// output channel. A push and a pop take the same steps: accept, a scan in
// which the single read port of the entry memory visits each of the CAPACITY
// slots in turn, a compare of the last slot, and a write-back that also loads
// the result register. The input is taken again right after the write-back,
// even while that result still waits in the output register; the write-back
// of a following transaction waits only if the output register is still full.
// Slot occupancy is held in per-slot valid flops cleared by reset, so the
// block needs no clearing pass and accepts work in the first cycle after
// reset. The transmit_limit register sits at byte address 0 of the APB port
// (word index paddr[2]); write it only while the block is idle.
// ----------------------------------------------------------------------------
module retransmit_priority_queue
  import rpq_pkg::*;
#(
  parameter int CAPACITY = DEFAULT_CAPACITY
) (
  input  logic                  clk,
  input  logic                  rst,
  rpq_in_if.sink                in_ch,
  rpq_out_if.source             out_ch,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  rpq_cmd_t           cmd;
  rpq_stat_t          stat;
  logic [SENDS_W-1:0] transmit_limit;

  // Configuration register: write on the access phase, decode on word index
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      transmit_limit <= LIMIT_RESET;
    end else if (psel && penable && pwrite && pready &&
                 (paddr[2] == REG_TRANSMIT_LIMIT)) begin
      transmit_limit <= pwdata[SENDS_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_TRANSMIT_LIMIT) begin
      prdata = {{(APB_DATA_W - SENDS_W){1'b0}}, transmit_limit};
    end
  end

  // Sequencer: drives accept, scan, and write-back steps
  rpq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Slot table, compare and result register
  rpq_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .in_cmd         (in_ch.cmd),
    .in_node_id     (in_ch.node_id),
    .transmit_limit (transmit_limit),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .out_sent_node  (out_ch.sent_node),
    .out_status     (out_ch.status),
    .out_retired    (out_ch.retired),
    .out_occupancy  (out_ch.occupancy)
  );

endmodule

// ===== tb/retransmit_priority_queue_tb.sv =====
// ----------------------------------------------------------------------------
// retransmit_priority_queue_tb
// Self-checking bench for the broadcast retransmit table: a scoreboard class
// predicts each result from its own copy of the slot table, and the bench
// drives push/pop transactions under several transmit limits and idle mixes.
// ----------------------------------------------------------------------------
module retransmit_priority_queue_tb;
  import rpq_pkg::*;

  localparam int SLOTS          = DEFAULT_CAPACITY;
  localparam int POOL_SIZE      = 24;       // more handles than slots, so the table fills
  localparam int SETTLE_CYCLES  = SLOTS + 6;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASE_ITEMS    = 140;
  localparam logic [APB_ADDR_W-1:0] LIMIT_ADDR = APB_ADDR_W'({REG_TRANSMIT_LIMIT, 2'b00});

  typedef struct packed {
    logic [NODE_W-1:0]    sent_node;
    logic [STATUS_W-1:0]  status;
    logic                 retired;
    logic [OCC_OUT_W-1:0] occupancy;
  } txn_result_t;

  // --------------------------------------------------------------------------
  // Scoreboard: mirror of the slot table plus the queue of expected results.
  // --------------------------------------------------------------------------
  class retransmit_scoreboard;
    logic [SENDS_W-1:0] limit = LIMIT_RESET;
    bit                 held[SLOTS];
    logic [NODE_W-1:0]  node_of[SLOTS];
    logic [SENDS_W-1:0] sends_of[SLOTS];
    logic [STAMP_W-1:0] stamp_of[SLOTS];
    logic [STAMP_W-1:0] stamp_now = '0;
    txn_result_t        expected_q[$];
    int errors = 0, checked = 0;
    int pushes = 0, refreshes = 0, drops = 0, pops = 0, empty_pops = 0, retirements = 0;

    function int pending();
      return expected_q.size();
    endfunction

    // Apply one accepted transaction to the mirror and queue its result.
    function void note_input(logic cmd, logic [NODE_W-1:0] node);
      txn_result_t r;
      int hit, free_slot, best, count;
      r = '0;
      if (cmd == CMD_PUSH) begin
        pushes++;
        hit = -1;
        free_slot = -1;
        for (int i = 0; i < SLOTS; i++) begin
          if (held[i]) begin
            if (hit < 0 && node_of[i] == node) hit = i;
          end else if (free_slot < 0) begin
            free_slot = i;
          end
        end
        if (hit >= 0) refreshes++;
        else hit = free_slot;
        if (hit < 0) begin
          r.status = STATUS_FULL;
          drops++;
        end else begin
          stamp_now++;
          held[hit]     = 1'b1;
          node_of[hit]  = node;
          sends_of[hit] = '0;
          stamp_of[hit] = stamp_now;
        end
      end else begin
        pops++;
        best = -1;
        for (int i = 0; i < SLOTS; i++) begin
          if (held[i] && (best < 0 || sends_of[i] < sends_of[best] ||
              (sends_of[i] == sends_of[best] && stamp_of[i] > stamp_of[best])))
            best = i;
        end
        if (best < 0) begin
          r.status = STATUS_EMPTY;
          empty_pops++;
        end else begin
          r.sent_node = node_of[best];
          if (int'(sends_of[best]) + 1 >= int'(limit)) begin
            held[best] = 1'b0;
            r.retired  = 1'b1;
            retirements++;
          end else begin
            sends_of[best] = sends_of[best] + 1'b1;
          end
        end
      end
      count = 0;
      foreach (held[i]) count += held[i];
      r.occupancy = OCC_OUT_W'(count);
      expected_q = {expected_q, r};
    endfunction

    task report_error(string msg);
      errors++;
      $display("ERROR @%0t result %0d: %s", $time, checked, msg);
    endtask

    // Compare one accepted result with the oldest expectation.
    task check_result(txn_result_t got);
      txn_result_t want;
      if (expected_q.size() == 0) begin
        report_error($sformatf("unexpected result %p", got));
        return;
      end
      want = expected_q.pop_front();
      if (got.sent_node !== want.sent_node)
        report_error($sformatf("sent_node %h, expected %h", got.sent_node, want.sent_node));
      if (got.status !== want.status)
        report_error($sformatf("status %0d, expected %0d", got.status, want.status));
      if (got.retired !== want.retired)
        report_error($sformatf("retired %b, expected %b", got.retired, want.retired));
      if (got.occupancy !== want.occupancy)
        report_error($sformatf("occupancy %0d, expected %0d", got.occupancy, want.occupancy));
      checked++;
    endtask
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset, channels and the block itself
  // --------------------------------------------------------------------------
  logic                  clk;
  logic                  rst;
  logic                  psel, penable, pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  rpq_in_if  in_ch();
  rpq_out_if out_ch();

  retransmit_priority_queue #(.CAPACITY(SLOTS)) DUT (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  retransmit_scoreboard sb = new;

  int                sender_idle_pct = 0;   // chance per cycle to hold off the next transaction
  int                recv_stall_pct  = 0;   // chance per cycle to drop ready on the result side
  int                quiet_cycles;
  logic [NODE_W-1:0] id_pool[POOL_SIZE];

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Driver tasks
  // --------------------------------------------------------------------------

  // Present one transaction, optionally after an idle gap, and hold it until
  // the block takes it. Valid is left high so back-to-back items need no
  // extra assignment; the caller lowers it when stimulus pauses.
  task automatic send_txn(input logic cmd, input logic [NODE_W-1:0] node);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.cmd     <= cmd;
    in_ch.node_id <= node;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_input(cmd, node);
  endtask

  // APB write of the transmit limit, setup phase then access phase; the register
  // takes the value at the access-cycle edge, so update the mirror only after that edge.
  task automatic write_limit(input logic [SENDS_W-1:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= LIMIT_ADDR;
    pwdata  <= APB_DATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.limit = value;
  endtask

  // Wait for every expected result, then let the pipeline settle.
  task automatic wait_quiet();
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Random push/pop mix. Most handles come from a small pool so that refreshes,
  // a full table and ties on the send count all occur; the push share moves in
  // chunks to swing the table between empty and full.
  task automatic run_random(input int count);
    int                push_pct;
    logic              cmd;
    logic [NODE_W-1:0] node;
    push_pct = 50;
    for (int k = 0; k < count; k++) begin
      if (k % 40 == 0) begin
        case ($urandom_range(2))
          0:       push_pct = 25;
          1:       push_pct = 55;
          default: push_pct = 80;
        endcase
      end
      cmd  = ($urandom_range(99) < push_pct) ? CMD_PUSH : CMD_POP;
      node = ($urandom_range(99) < 85) ? id_pool[$urandom_range(POOL_SIZE-1)]
                                       : NODE_W'($urandom);
      send_txn(cmd, node);
    end
    in_ch.valid <= 1'b0;
  endtask

  // One phase: drain, set the limit while idle, pick the idle mix, run.
  task automatic run_phase(input logic [SENDS_W-1:0] limit, input int idle_pct,
                           input int stall_pct);
    wait_quiet();
    write_limit(limit);
    sender_idle_pct = idle_pct;
    recv_stall_pct  = stall_pct;
    run_random(PHASE_ITEMS);
  endtask

  // --------------------------------------------------------------------------
  // Result side: check every accepted result, then pick the next ready.
  // --------------------------------------------------------------------------
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_ch.valid && out_ch.ready)
        sb.check_result(txn_result_t'{out_ch.sent_node, out_ch.status,
                                      out_ch.retired, out_ch.occupancy});
      out_ch.ready <= !rst && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: end the run when no transaction moves for too long.
  // --------------------------------------------------------------------------
  initial begin
    quiet_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("TIMEOUT: no transaction for %0d cycles, %0d results outstanding",
                 quiet_cycles, sb.pending());
        $display("retransmit_priority_queue: mismatch");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    // Drive every input to a known value before the first edge.
    rst           <= 1'b1;
    in_ch.valid   <= 1'b0;
    in_ch.cmd     <= CMD_PUSH;
    in_ch.node_id <= '0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    foreach (id_pool[i]) id_pool[i] = NODE_W'($urandom);

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed part at the reset limit, no idling.
    send_txn(CMD_POP,  16'h1234);               // pop on an empty table
    send_txn(CMD_PUSH, 16'h0000);               // lowest handle
    send_txn(CMD_PUSH, 16'hFFFF);               // highest handle
    send_txn(CMD_PUSH, 16'h0000);               // refresh a held node in place
    send_txn(CMD_POP,  16'hFFFF);               // tie on sends: newest wins
    send_txn(CMD_POP,  16'h0000);               // fewer sends wins
    for (int i = 1; i <= 14; i++)
      send_txn(CMD_PUSH, NODE_W'(i * 16'h1111)); // fill every slot
    send_txn(CMD_PUSH, 16'hABCD);               // new node into a full table: dropped
    send_txn(CMD_PUSH, 16'h3333);               // held node while full: refreshed
    send_txn(CMD_POP,  16'h5A5A);               // pop ignores the payload handle
    in_ch.valid <= 1'b0;

    // Random part: sweep the limit through its extremes and the idle mixes.
    run_phase(8'd1,   0,  0);
    run_phase(8'd255, 64, 0);
    run_phase(8'd0,   0,  64);                  // zero limit: every pop retires
    run_phase(8'd2,   27, 27);
    run_phase(SENDS_W'($urandom_range(4, 254)), 64, 0);
    run_phase(8'd3,   0,  0);
    run_phase(8'd255, 27, 27);

    wait_quiet();

    $display("Checked %0d results: %0d pushes (%0d refreshes, %0d dropped full), %0d pops",
             sb.checked, sb.pushes, sb.refreshes, sb.drops, sb.pops);
    $display("Pops on empty table: %0d, retirements: %0d, limits 0/1/2/3/255 and one random",
             sb.empty_pops, sb.retirements);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("retransmit_priority_queue: match");
    end else begin
      $display("retransmit_priority_queue: mismatch");
    end
    $finish;
  end

endmodule

// ===== retransmit_priority_queue.f =====
hdl/rpq_pkg.sv
hdl/rpq_if.sv
hdl/rpq_ctrl.sv
hdl/rpq_dp.sv
hdl/retransmit_priority_queue.sv
tb/retransmit_priority_queue_tb.sv
